[rtl/wce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wce_pkg - shared types and constants of the clique extender
// Table geometry, opcodes, item and result records, and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package wce_pkg;

  localparam int MAX_RESIDUES = 64;
  localparam int RES_BITS     = $clog2(MAX_RESIDUES);
  localparam int LIMIT_BITS   = RES_BITS + 1;
  localparam int MAX_MEMBERS  = 16;
  localparam int MEM_BITS     = $clog2(MAX_MEMBERS);
  localparam int CNT_BITS     = MEM_BITS + 1;
  localparam int WEIGHT_BITS  = 32;
  localparam int TABLE_DEPTH  = MAX_RESIDUES * MAX_RESIDUES;
  localparam int ADDR_BITS    = 2 * RES_BITS;

  localparam logic [LIMIT_BITS-1:0] RESET_COUNT = LIMIT_BITS'(MAX_RESIDUES);

  typedef enum logic [1:0] {
    OP_LINK   = 2'd0,
    OP_MEMBER = 2'd1,
    OP_EXTEND = 2'd2,
    OP_NONE   = 2'd3
  } wce_op_t;

  typedef struct packed {
    logic [1:0]                    opcode;
    logic [RES_BITS-1:0]           from_residue;
    logic [RES_BITS-1:0]           to_residue;
    logic signed [WEIGHT_BITS-1:0] link_weight;
    logic                          link_present;
    logic [RES_BITS-1:0]           member_residue;
    logic                          start_new_clique;
    logic signed [WEIGHT_BITS-1:0] start_size;
  } wce_item_t;

  typedef struct packed {
    logic [RES_BITS-1:0]           added_residue;
    logic signed [WEIGHT_BITS-1:0] extended_size;
    logic                          has_extension;
    logic [CNT_BITS-1:0]           extended_order;
    logic                          last_result;
  } wce_result_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;
    logic take;
    logic issue;
    logic finish;
  } wce_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic scan_more;
    logic chk_busy;
    logic stall;
    logic out_free;
  } wce_stat_t;

endpackage

[rtl/wce_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wce_in_if - input item channel
// Valid/ready channel carrying one command item per beat.
// ----------------------------------------------------------------------------
interface wce_in_if
  import wce_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [RES_BITS-1:0]           from_residue;
  logic [RES_BITS-1:0]           to_residue;
  logic signed [WEIGHT_BITS-1:0] link_weight;
  logic                          link_present;
  logic [RES_BITS-1:0]           member_residue;
  logic                          start_new_clique;
  logic signed [WEIGHT_BITS-1:0] start_size;

  modport source (
    output valid, opcode, from_residue, to_residue, link_weight, link_present,
           member_residue, start_new_clique, start_size,
    input  ready
  );
  modport sink (
    input  valid, opcode, from_residue, to_residue, link_weight, link_present,
           member_residue, start_new_clique, start_size,
    output ready
  );
endinterface

[rtl/wce_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wce_out_if - result channel
// Valid/ready channel carrying one extension result per beat.
// ----------------------------------------------------------------------------
interface wce_out_if
  import wce_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic [RES_BITS-1:0]           added_residue;
  logic signed [WEIGHT_BITS-1:0] extended_size;
  logic                          has_extension;
  logic [CNT_BITS-1:0]           extended_order;
  logic                          last_result;

  modport source (
    output valid, added_residue, extended_size, has_extension, extended_order,
           last_result,
    input  ready
  );
  modport sink (
    input  valid, added_residue, extended_size, has_extension, extended_order,
           last_result,
    output ready
  );
endinterface

[rtl/wce_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wce_cfg_if - configuration write channel
// Valid/ready channel carrying the residue count register value.
// ----------------------------------------------------------------------------
interface wce_cfg_if
  import wce_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [LIMIT_BITS-1:0] residue_count;

  modport source (output valid, residue_count, input ready);
  modport sink (input valid, residue_count, output ready);
endinterface

[rtl/wce_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wce_ctrl - clique extender sequencer
// Runs the table clearing pass, takes items when idle and paces the scan.
// ----------------------------------------------------------------------------
module wce_ctrl
  import wce_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic [1:0] in_opcode,
  output logic      in_ready,
  input  wce_stat_t stat,
  output wce_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_SCAN  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && (in_opcode == OP_EXTEND)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue  = stat.scan_more && !stat.stall;
        cmd.finish = !stat.scan_more && !stat.chk_busy && stat.out_free;
        if (cmd.finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

[rtl/wce_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wce_dp - clique extender datapath
// Link memory, clique member file, scan counters, lookup check stage,
// one-deep hold of the latest extension and the output register.
// ----------------------------------------------------------------------------
module wce_dp
  import wce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  wce_cmd_t              cmd,
  output wce_stat_t             stat,
  input  wce_item_t             item,
  input  logic                  cfg_we,
  input  logic [LIMIT_BITS-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output wce_result_t           out_data
);

  // Link memory word: valid bit on top of the weight
  logic [WEIGHT_BITS:0]          link_mem [TABLE_DEPTH];
  logic [WEIGHT_BITS:0]          rd_data;
  logic                          mem_we;
  logic [ADDR_BITS-1:0]          wr_addr;
  logic [WEIGHT_BITS:0]          wr_data;
  logic [ADDR_BITS-1:0]          rd_addr;
  logic [ADDR_BITS-1:0]          clr_addr;

  logic [LIMIT_BITS-1:0]         residue_count;
  logic [LIMIT_BITS-1:0]         limit;

  logic [RES_BITS-1:0]           members [MAX_MEMBERS];
  logic [CNT_BITS-1:0]           member_count;
  logic [CNT_BITS-1:0]           count_base;
  logic [RES_BITS-1:0]           last_member;

  logic [LIMIT_BITS-1:0]         cand;
  logic [MEM_BITS-1:0]           mem_idx;
  logic                          idx_last;
  logic signed [WEIGHT_BITS-1:0] init_size;

  logic                          chk_valid;
  logic [RES_BITS-1:0]           chk_cand;
  logic                          chk_first;
  logic                          chk_lastm;
  logic                          acc_ok;
  logic signed [WEIGHT_BITS-1:0] acc_size;
  logic                          ok_now;
  logic signed [WEIGHT_BITS-1:0] base_size;
  logic signed [WEIGHT_BITS-1:0] link_wt;
  logic signed [WEIGHT_BITS-1:0] size_now;
  logic                          qualify;

  logic                          hold_valid;
  logic [RES_BITS-1:0]           hold_res;
  logic signed [WEIGHT_BITS-1:0] hold_size;

  logic                          out_free;
  logic                          stall;
  logic                          chk_push;
  logic                          push;
  wce_result_t                   push_data;

  logic take_link;
  logic take_member;
  logic take_extend;

  assign take_link   = cmd.take && (item.opcode == OP_LINK);
  assign take_member = cmd.take && (item.opcode == OP_MEMBER);
  assign take_extend = cmd.take && (item.opcode == OP_EXTEND);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      residue_count <= RESET_COUNT;
    end else if (cfg_we) begin
      residue_count <= cfg_data;
    end
  end

  assign limit = (residue_count > RESET_COUNT) ? RESET_COUNT : residue_count;

  // Link memory: one write port shared by clearing pass and link items
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (cmd.clear_step) begin
      mem_we = 1'b1;
    end else if (take_link) begin
      mem_we  = 1'b1;
      wr_addr = {item.from_residue, item.to_residue};
      wr_data = {item.link_present, item.link_weight};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[wr_addr] <= wr_data;
    end
  end

  assign rd_addr = {members[mem_idx], cand[RES_BITS-1:0]};

  // Read data holds while no lookup issues, which keeps a stalled check stable
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Clique member file
  assign count_base = item.start_new_clique ? '0 : member_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      member_count <= '0;
    end else if (take_member && (count_base < CNT_BITS'(MAX_MEMBERS))) begin
      member_count <= count_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_member && (count_base < CNT_BITS'(MAX_MEMBERS))) begin
      members[count_base[MEM_BITS-1:0]] <= item.member_residue;
      last_member                       <= item.member_residue;
    end
  end

  // Scan counters: members inner, candidates outer
  assign idx_last = ({1'b0, mem_idx} == (member_count - 1'b1));

  always_ff @(posedge clk) begin
    if (take_extend) begin
      cand      <= {1'b0, last_member} + 1'b1;
      mem_idx   <= '0;
      init_size <= item.start_size;
    end else if (cmd.issue) begin
      if (idx_last) begin
        mem_idx <= '0;
        cand    <= cand + 1'b1;
      end else begin
        mem_idx <= mem_idx + 1'b1;
      end
    end
  end

  // Check stage: fold one lookup per cycle, unless stalled, into the candidate's verdict
  assign base_size = chk_first ? init_size : acc_size;
  assign link_wt   = rd_data[WEIGHT_BITS-1:0];
  assign ok_now    = (chk_first || acc_ok) && rd_data[WEIGHT_BITS];
  assign size_now  = (link_wt > base_size) ? link_wt : base_size;
  assign qualify   = chk_valid && chk_lastm && ok_now;

  assign out_free = !out_valid || out_ready;
  assign stall    = qualify && hold_valid && !out_free;
  assign chk_push = qualify && hold_valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (!stall) begin
      chk_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      chk_cand  <= cand[RES_BITS-1:0];
      chk_first <= (mem_idx == '0);
      chk_lastm <= idx_last;
    end
    if (chk_valid && !stall) begin
      acc_ok   <= ok_now;
      acc_size <= size_now;
    end
  end

  // Hold the latest extension until the next one, or the scan end, marks it
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take_extend) begin
      hold_valid <= 1'b0;
    end else if (qualify && !stall) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (qualify && !stall) begin
      hold_res  <= chk_cand;
      hold_size <= size_now;
    end
  end

  // Output register
  assign push = chk_push || cmd.finish;

  always_comb begin
    if (hold_valid) begin
      push_data.added_residue  = hold_res;
      push_data.extended_size  = hold_size;
      push_data.has_extension  = 1'b1;
      push_data.extended_order = member_count + 1'b1;
    end else begin
      push_data.added_residue  = '0;
      push_data.extended_size  = init_size;
      push_data.has_extension  = 1'b0;
      push_data.extended_order = member_count;
    end
    push_data.last_result = cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= push || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= push_data;
    end
  end

  // Status
  assign stat.clear_last = (clr_addr == '1);
  assign stat.scan_more  = (member_count != '0) && (cand < limit);
  assign stat.chk_busy   = chk_valid;
  assign stat.stall      = stall;
  assign stat.out_free   = out_free;

endmodule

[rtl/weighted_clique_extender_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_clique_extender_unit - weighted clique extension engine
// Keeps a residue link table and a clique, and lists the residues that
// extend the clique together with the extended size.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready input. Link beats write or clear one table entry,
//            member beats append to the clique, extend beats start a scan.
//   result : valid/ready output, one beat per qualifying residue in
//            ascending order; last_result marks the final beat. A scan that
//            finds nothing sends a single orphan beat.
//   cfg    : residue count writes, always ready; write only while idle.
// Scan: link and member beats are taken back to back while idle. An extend
//   beat runs one link memory lookup per member per candidate through the
//   single read port, for each candidate above the last member and below the
//   residue count; output stalls hold the scan. item is not ready during a
//   scan.
// Reset: a clearing pass sweeps the 4096-entry link memory, one entry per
//   cycle, and item ready rises once that pass is done.
// Backpressure: the output register frees its slot in the cycle it is
//   taken; with it full and a second extension found, the scan stalls.
// ----------------------------------------------------------------------------
module weighted_clique_extender_unit
  import wce_pkg::*;
(
  input logic        clk,
  input logic        rst,
  wce_in_if.sink     item,
  wce_out_if.source  result,
  wce_cfg_if.sink    cfg
);

  wce_cmd_t    cmd;
  wce_stat_t   stat;
  wce_item_t   item_data;
  wce_result_t res_data;
  logic        in_ready;

  // Pack the item beat for the datapath
  assign item_data.opcode           = item.opcode;
  assign item_data.from_residue     = item.from_residue;
  assign item_data.to_residue       = item.to_residue;
  assign item_data.link_weight      = item.link_weight;
  assign item_data.link_present     = item.link_present;
  assign item_data.member_residue   = item.member_residue;
  assign item_data.start_new_clique = item.start_new_clique;
  assign item_data.start_size       = item.start_size;

  assign item.ready = in_ready;
  assign cfg.ready  = 1'b1;

  wce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_opcode (item.opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wce_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item_data),
    .cfg_we    (cfg.valid),
    .cfg_data  (cfg.residue_count),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (res_data)
  );

  // Unpack the result beat
  assign result.added_residue  = res_data.added_residue;
  assign result.extended_size  = res_data.extended_size;
  assign result.has_extension  = res_data.has_extension;
  assign result.extended_order = res_data.extended_order;
  assign result.last_result    = res_data.last_result;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the weighted clique extender
// Drives link, member, extend and idle command beats through the item channel,
// rewrites the residue count between phases and predicts every result beat
// from a private copy of the link table and clique, checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import wce_pkg::*;

  // Hold off longer than the longest scan without output stalls before
  // touching the count register, and let the watchdog outlast both the hold
  // and the clearing pass after reset.
  localparam int HOLD_OFF       = 1100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 32;

  logic clk;
  logic rst;

  wce_in_if  cmd_ch ();
  wce_out_if ext_ch ();
  wce_cfg_if cnt_ch ();

  weighted_clique_extender_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (cmd_ch),
    .result (ext_ch),
    .cfg    (cnt_ch)
  );

  // Link table and clique as the block should hold them
  bit                            link_on [TABLE_DEPTH];
  logic signed [WEIGHT_BITS-1:0] link_wt [TABLE_DEPTH];
  logic [RES_BITS-1:0]           clique  [MAX_MEMBERS];
  int                            clique_len;
  logic [LIMIT_BITS-1:0]         count_reg;

  wce_item_t   cmd_backlog[$];     // command beats not yet offered
  wce_result_t extensions_due[$];  // result beats predicted, oldest first
  wce_item_t   on_wire;            // beat currently offered on the item channel
  wce_result_t head;

  int send_gap_pct;
  int stall_pct;
  int n_fail;
  int n_accepted;
  int n_extend;
  int n_results;
  int n_counts;
  int quiet_cycles;

  always #5 clk = ~clk;

  function automatic void queue_cmd(wce_item_t it);
    cmd_backlog.insert(cmd_backlog.size(), it);
  endfunction

  function automatic void expect_result(wce_result_t r);
    extensions_due.insert(extensions_due.size(), r);
  endfunction

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Scan every residue above the last member and below the effective count;
  // a candidate qualifies only if every member links to it.
  function automatic void extend_clique(logic signed [WEIGHT_BITS-1:0] init);
    int                            limit;
    int                            last;
    int                            idx;
    bit                            linked;
    bit                            have_prev;
    logic signed [WEIGHT_BITS-1:0] best;
    wce_result_t                   r;
    wce_result_t                   prev;
    limit = (count_reg > MAX_RESIDUES) ? MAX_RESIDUES : int'(count_reg);
    have_prev = 1'b0;
    prev = '0;
    // Empty clique: no scan, a single orphan beat of order zero
    if (clique_len == 0) begin
      r = '0;
      r.extended_size = init;
      r.last_result = 1'b1;
      expect_result(r);
      return;
    end
    last = clique[clique_len-1];
    for (int cand = last + 1; cand < limit; cand++) begin
      best = init;
      linked = 1'b1;
      for (int j = 0; j < clique_len; j++) begin
        idx = clique[j] * MAX_RESIDUES + cand;
        if (!link_on[idx]) begin
          linked = 1'b0;
        end else if (link_wt[idx] > best) begin
          best = link_wt[idx];
        end
      end
      if (linked) begin
        if (have_prev) expect_result(prev);
        prev = '0;
        prev.added_residue = RES_BITS'(cand);
        prev.extended_size = best;
        prev.has_extension = 1'b1;
        prev.extended_order = CNT_BITS'(clique_len + 1);
        have_prev = 1'b1;
      end
    end
    if (have_prev) begin
      // Mark the final qualifying residue
      prev.last_result = 1'b1;
      expect_result(prev);
    end else begin
      r = '0;
      r.extended_size = init;
      r.extended_order = CNT_BITS'(clique_len);
      r.last_result = 1'b1;
      expect_result(r);
    end
  endfunction

  function automatic void apply_command(wce_item_t c);
    case (c.opcode)
      OP_LINK: begin
        // Removal drops the valid bit only; the weight stays behind
        if (c.link_present) begin
          link_on[{c.from_residue, c.to_residue}] = 1'b1;
          link_wt[{c.from_residue, c.to_residue}] = c.link_weight;
        end else begin
          link_on[{c.from_residue, c.to_residue}] = 1'b0;
        end
      end
      OP_MEMBER: begin
        if (c.start_new_clique) clique_len = 0;
        // A full clique ignores further members
        if (clique_len < MAX_MEMBERS) begin
          clique[clique_len] = c.member_residue;
          clique_len++;
        end
      end
      OP_EXTEND: begin
        n_extend++;
        extend_clique(c.start_size);
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Fill every field at random so unused fields toggle too
  function automatic wce_item_t random_item();
    wce_item_t it;
    it.opcode = 2'($urandom_range(3));
    it.from_residue = RES_BITS'($urandom);
    it.to_residue = RES_BITS'($urandom);
    it.link_weight = $urandom;
    it.link_present = 1'($urandom);
    it.member_residue = RES_BITS'($urandom);
    it.start_new_clique = 1'($urandom);
    it.start_size = $urandom;
    return it;
  endfunction

  function automatic wce_item_t mk_link(int from, int to, logic [31:0] w, bit present);
    wce_item_t it;
    it = random_item();
    it.opcode = OP_LINK;
    it.from_residue = RES_BITS'(from);
    it.to_residue = RES_BITS'(to);
    it.link_weight = w;
    it.link_present = present;
    return it;
  endfunction

  function automatic wce_item_t mk_member(int res, bit fresh);
    wce_item_t it;
    it = random_item();
    it.opcode = OP_MEMBER;
    it.member_residue = RES_BITS'(res);
    it.start_new_clique = fresh;
    return it;
  endfunction

  function automatic wce_item_t mk_extend(logic [31:0] init);
    wce_item_t it;
    it = random_item();
    it.opcode = OP_EXTEND;
    it.start_size = init;
    return it;
  endfunction

  // Mix full-range, near-zero, saturated and small-integer Q16.16 weights
  function automatic logic [31:0] pick_weight();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return {16'($urandom_range(0, 7)) - 16'd3, 16'($urandom)};
    endcase
  endfunction

  // One well-formed round: links from a small residue pool to a few
  // candidates above it, the pool as the new clique, then an extend.
  // Some rounds are plain noise instead.
  task automatic stage_clique_round();
    logic [RES_BITS-1:0] pool[$];
    logic [RES_BITS-1:0] mem_list[$];
    int                  n_pool;
    int                  n_cand;
    int                  cand;
    int                  top;
    bit                  full;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 4)) queue_cmd(random_item());
      return;
    end
    n_pool = $urandom_range(1, 4);
    repeat (n_pool) pool.insert(pool.size(), RES_BITS'($urandom_range(0, 44)));
    pool.sort();
    top = pool[n_pool-1];
    // Now and then overfill the clique so the extra member is dropped
    full = ($urandom_range(99) < 8);
    n_cand = full ? 1 : $urandom_range(1, 5);
    repeat (n_cand) begin
      cand = $urandom_range(top + 1, MAX_RESIDUES - 1);
      foreach (pool[i])
        queue_cmd(mk_link(pool[i], cand, pick_weight(), $urandom_range(99) < 88));
    end
    mem_list = pool;
    if (full) begin
      while (mem_list.size() < MAX_MEMBERS + 1)
        mem_list.insert(mem_list.size(), pool[$urandom_range(0, n_pool - 1)]);
    end else if ($urandom_range(99) < 15) begin
      mem_list.shuffle();
    end
    foreach (mem_list[i])
      queue_cmd(mk_member(mem_list[i], i == 0 && $urandom_range(99) < 92));
    queue_cmd(mk_extend(pick_weight()));
  endtask

  // Wait for every beat to drain, then hold out one full scan; sample between
  // edges so a beat the driver offers at an edge is already visible
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || extensions_due.size() != 0)
      @(negedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_residue_count(logic [LIMIT_BITS-1:0] v);
    @(posedge clk);
    cnt_ch.valid <= 1'b1;
    cnt_ch.residue_count <= v;
    do @(posedge clk); while (!(cnt_ch.valid && cnt_ch.ready));
    count_reg = v;
    n_counts++;
    cnt_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Item driver: offer the backlog, apply each beat to the prediction when
  // it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        apply_command(on_wire);
        n_accepted++;
      end
      // Advance only when the channel is empty or the beat was just taken
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          on_wire = cmd_backlog.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.opcode <= on_wire.opcode;
          cmd_ch.from_residue <= on_wire.from_residue;
          cmd_ch.to_residue <= on_wire.to_residue;
          cmd_ch.link_weight <= on_wire.link_weight;
          cmd_ch.link_present <= on_wire.link_present;
          cmd_ch.member_residue <= on_wire.member_residue;
          cmd_ch.start_new_clique <= on_wire.start_new_clique;
          cmd_ch.start_size <= on_wire.start_size;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each taken beat with the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      n_fail++;
      $display("%0t ns  %s: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ext_ch.ready <= 1'b0;
    end else begin
      if (ext_ch.valid && ext_ch.ready) begin
        n_results++;
        if (extensions_due.size() == 0) begin
          n_fail++;
          $display("%0t ns  result beat with none expected: residue %0d size %0d",
                   $time, ext_ch.added_residue, ext_ch.extended_size);
        end else begin
          head = extensions_due.pop_front();
          check_field("added_residue", head.added_residue, ext_ch.added_residue);
          check_field("extended_size", head.extended_size, ext_ch.extended_size);
          check_field("has_extension", head.has_extension, ext_ch.has_extension);
          check_field("extended_order", head.extended_order, ext_ch.extended_order);
          check_field("last_result", head.last_result, ext_ch.last_result);
        end
      end
      ext_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no beat moves on any channel for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (ext_ch.valid && ext_ch.ready) ||
        (cnt_ch.valid && cnt_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns  timeout: %0d results still expected", $time,
               extensions_due.size());
      $display("weighted_clique_extender_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: reset, directed beats, then random phases with new counts
  // --------------------------------------------------------------------------
  initial begin
    logic [LIMIT_BITS-1:0] count_plan[8];
    int                    start_len;
    count_plan = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd40, 7'd0, 7'd65, 7'd63};
    count_plan[5] = LIMIT_BITS'($urandom_range(1, MAX_RESIDUES));
    clk = 1'b0;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = OP_NONE;
    cmd_ch.from_residue = '0;
    cmd_ch.to_residue = '0;
    cmd_ch.link_weight = '0;
    cmd_ch.link_present = 1'b0;
    cmd_ch.member_residue = '0;
    cmd_ch.start_new_clique = 1'b0;
    cmd_ch.start_size = '0;
    ext_ch.ready = 1'b0;
    cnt_ch.valid = 1'b0;
    cnt_ch.residue_count = '0;
    send_gap_pct = 0;
    stall_pct = 0;
    n_fail = 0;
    n_accepted = 0;
    n_extend = 0;
    n_results = 0;
    n_counts = 0;
    quiet_cycles = 0;
    clique_len = 0;
    count_reg = RESET_COUNT;
    foreach (link_on[i]) link_on[i] = 1'b0;
    foreach (link_wt[i]) link_wt[i] = '0;
    foreach (clique[i]) clique[i] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the reset count, no idling.
    // Extend on an empty clique: orphan of order zero
    queue_cmd(mk_extend(32'h8000_0000));
    begin
      wce_item_t idle_op;
      idle_op = random_item();
      idle_op.opcode = OP_NONE;
      queue_cmd(idle_op);
    end
    // Extreme weights and residues at both ends of the table
    queue_cmd(mk_link(0, 63, 32'h7FFF_FFFF, 1'b1));
    queue_cmd(mk_link(0, 62, 32'h8000_0000, 1'b1));
    queue_cmd(mk_link(63, 0, 32'h0000_0000, 1'b1));
    // Set then remove a link; the candidate must drop out
    queue_cmd(mk_link(0, 61, 32'h0000_0001, 1'b1));
    queue_cmd(mk_link(0, 61, 32'h0000_FFFF, 1'b0));
    queue_cmd(mk_member(0, 1'b1));
    queue_cmd(mk_extend(32'h0000_0000));
    queue_cmd(mk_extend(32'h7FFF_FFFF));
    // Last member at the top residue: nothing above it
    queue_cmd(mk_member(63, 1'b1));
    queue_cmd(mk_extend(pick_weight()));
    // Unsorted clique: only the last member bounds the scan
    queue_cmd(mk_member(62, 1'b1));
    queue_cmd(mk_member(0, 1'b0));
    queue_cmd(mk_extend(32'hFFFF_0000));
    queue_cmd(mk_link(62, 63, 32'h0000_0005, 1'b1));
    queue_cmd(mk_extend(32'hFFFF_FFFD));
    // Repeated member
    queue_cmd(mk_member(0, 1'b0));
    queue_cmd(mk_extend(32'h0000_0001));
    wait_idle();

    // Random phases: rotate through the idling styles, one count each
    for (int p = 0; p < 8; p++) begin
      write_residue_count(count_plan[p]);
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 58; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 58; end
        default: begin send_gap_pct = 20; stall_pct = 20; end
      endcase
      start_len = n_accepted + cmd_backlog.size();
      while (n_accepted + cmd_backlog.size() - start_len < PHASE_ITEMS)
        stage_clique_round();
      wait_idle();
    end

    $display("Covered %0d command beats with %0d extend requests and %0d result beats,",
             n_accepted, n_extend, n_results);
    $display("across %0d residue count writes including 0, 1, 64, 65 and 127.", n_counts);
    if (n_fail == 0) begin
      $display("weighted_clique_extender_unit: match");
    end else begin
      $display("weighted_clique_extender_unit: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/wce_pkg.sv
rtl/wce_in_if.sv
rtl/wce_out_if.sv
rtl/wce_cfg_if.sv
rtl/wce_ctrl.sv
rtl/wce_dp.sv
rtl/weighted_clique_extender_unit.sv
tb/tb.sv
